@@ sv/arp_pkg.sv @@
package arp_pkg;

	// command codes on the item channel
	typedef enum logic [1:0] {
		CMD_STORE = 2'd0,
		CMD_START = 2'd1,
		CMD_EMIT  = 2'd2,
		CMD_NONE  = 2'd3
	} arp_cmd_code_t;

	// configuration register indexes
	localparam logic [2:0] REG_PCM24_MODE     = 3'd0;
	localparam logic [2:0] REG_MONO_TO_STEREO = 3'd1;
	localparam logic [2:0] REG_SHORT_WORDS    = 3'd2;
	localparam logic [2:0] REG_SHORT_COUNT    = 3'd3;
	localparam logic [2:0] REG_LONG_COUNT     = 3'd4;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned LEN_W  = 7;
	localparam int unsigned CAD_W  = 9;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LEN,
		ST_READ,
		ST_SEND,
		ST_DUP
	} arp_state_t;

	// controller to datapath
	typedef struct packed {
		logic clear_wr;
		logic store_wr;
		logic start_idx;
		logic emit_init;
		logic rd_issue;
		logic send_word;
		logic send_dup;
	} arp_ctl_t;

	// datapath to controller
	typedef struct packed {
		logic clear_last;
		logic len_zero;
		logic more;
		logic mono;
	} arp_stat_t;

	// pcm24: rotate left 8 then shift left 8; pcm32: swap halves
	function automatic logic [WORD_W-1:0] reorder(input logic [WORD_W-1:0] t,
		input logic pcm24);
		logic [WORD_W-1:0] r;
		if (pcm24) begin
			r = {t[15:0], t[31:24], 8'h00};
		end else begin
			r = {t[15:0], t[31:16]};
		end
		return r;
	endfunction

endpackage

@@ sv/arp_ctrl.sv @@
module arp_ctrl
	import arp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] command,
	input  arp_stat_t  stat,
	output logic       busy,
	output arp_ctl_t   ctl
);

	arp_state_t state_q, state_nx;
	arp_cmd_code_t cmd;

	assign cmd = arp_cmd_code_t'(command);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		ctl      = '0;
		busy     = (state_q != ST_IDLE);
		case (state_q)
			ST_CLEAR: begin
				ctl.clear_wr = 1'b1;
				if (stat.clear_last) begin
					state_nx = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					case (cmd)
						CMD_STORE: ctl.store_wr = 1'b1;
						CMD_START: ctl.start_idx = 1'b1;
						CMD_EMIT: begin
							ctl.emit_init = 1'b1;
							state_nx      = ST_LEN;
						end
						default: ;
					endcase
				end
			end
			ST_LEN: begin
				state_nx = stat.len_zero ? ST_IDLE : ST_READ;
			end
			ST_READ: begin
				ctl.rd_issue = 1'b1;
				state_nx     = ST_SEND;
			end
			ST_SEND: begin
				ctl.send_word = 1'b1;
				if (stat.mono && stat.more) begin
					state_nx = ST_DUP;
				end else if (stat.more) begin
					state_nx = ST_READ;
				end else begin
					state_nx = ST_IDLE;
				end
			end
			ST_DUP: begin
				ctl.send_dup = 1'b1;
				state_nx     = stat.more ? ST_READ : ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

endmodule

@@ sv/arp_datapath.sv @@
module arp_datapath
	import arp_pkg::*;
#(
	parameter int unsigned RING_DEPTH       = 128,
	parameter int unsigned MAX_PACKET_WORDS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  arp_ctl_t          ctl,
	input  logic [WORD_W-1:0] captured_word,
	input  logic              cfg_wr,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	output arp_stat_t         stat,
	output logic              result_valid,
	output logic [WORD_W-1:0] sample_word,
	output logic              last_word,
	output logic [LEN_W-1:0]  packet_words
);

	localparam int unsigned AW = $clog2(RING_DEPTH);
	localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);
	localparam logic [AW-1:0] HALF_IDX = AW'(RING_DEPTH / 2);
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PACKET_WORDS);

	logic [WORD_W-1:0] ring [RING_DEPTH];
	logic [WORD_W-1:0] rdata_q;

	logic             pcm24_q, mono_q;
	logic [5:0]       short_words_q;
	logic [7:0]       short_count_q, long_count_q;
	logic [AW-1:0]    clr_q, wr_q, rd_q;
	logic [CAD_W-1:0] cadence_q;
	logic [LEN_W-1:0] len_q, n_q;

	logic             valid_q, last_q;
	logic [WORD_W-1:0] word_q;

	logic [AW-1:0]    wr_nx, rd_nx;
	logic [CAD_W-1:0] period, cad_inc;
	logic             is_long;
	logic [LEN_W-1:0] len_raw, n_inc;

	assign wr_nx   = (wr_q == LAST_IDX) ? '0 : wr_q + 1'b1;
	assign rd_nx   = (rd_q == LAST_IDX) ? '0 : rd_q + 1'b1;
	assign period  = {1'b0, short_count_q} + {1'b0, long_count_q};
	assign cad_inc = cadence_q + 1'b1;
	assign is_long = (period != '0) && (cadence_q >= {1'b0, short_count_q});
	assign len_raw = {1'b0, short_words_q} + (is_long ? LEN_W'(2) : LEN_W'(0));
	assign n_inc   = n_q + 1'b1;

	assign stat.clear_last = (clr_q == LAST_IDX);
	assign stat.len_zero   = (len_q == '0);
	assign stat.more       = (n_inc < len_q);
	assign stat.mono       = mono_q;

	// ring: one write port shared by clear and store, one registered read
	always_ff @(posedge clk) begin
		if (ctl.clear_wr) begin
			ring[clr_q] <= '0;
		end else if (ctl.store_wr) begin
			ring[wr_q] <= captured_word;
		end
		if (ctl.rd_issue) begin
			rdata_q <= ring[rd_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcm24_q       <= 1'b1;
			mono_q        <= 1'b0;
			short_words_q <= 6'd22;
			short_count_q <= 8'd1;
			long_count_q  <= 8'd0;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_PCM24_MODE:     pcm24_q       <= cfg_data[0];
				REG_MONO_TO_STEREO: mono_q        <= cfg_data[0];
				REG_SHORT_WORDS:    short_words_q <= cfg_data[5:0];
				REG_SHORT_COUNT:    short_count_q <= cfg_data[7:0];
				REG_LONG_COUNT:     long_count_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			wr_q      <= '0;
			rd_q      <= '0;
			cadence_q <= '0;
			len_q     <= '0;
			n_q       <= '0;
			valid_q   <= 1'b0;
		end else begin
			valid_q <= ctl.send_word | ctl.send_dup;
			if (ctl.clear_wr) begin
				clr_q <= clr_q + 1'b1;
			end
			if (ctl.store_wr) begin
				wr_q <= wr_nx;
			end
			if (ctl.start_idx) begin
				wr_q <= '0;
				rd_q <= HALF_IDX;
			end
			if (ctl.emit_init) begin
				// packet length and cadence position
				len_q     <= (len_raw > MAX_LEN) ? MAX_LEN : len_raw;
				cadence_q <= (period == '0 || cad_inc >= period) ? '0 : cad_inc;
				n_q       <= '0;
			end
			if (ctl.rd_issue) begin
				rd_q <= rd_nx;
			end
			if (ctl.send_word) begin
				n_q     <= n_inc;
			end
			if (ctl.send_dup) begin
				// second copy, skip the next source word
				n_q     <= n_inc;
				rd_q    <= rd_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.send_word) begin
			word_q <= reorder(rdata_q, pcm24_q);
		end
		if (ctl.send_word || ctl.send_dup) begin
			last_q <= (n_inc == len_q);
		end
	end

	assign result_valid = valid_q;
	assign sample_word  = word_q;
	assign last_word    = last_q;
	assign packet_words = len_q;

endmodule

@@ sv/audio_ring_packetizer.sv @@
// audio ring packetizer
// item channel: an item (command, captured_word) is taken at a clock edge with
//   start high and busy low. store writes captured_word into the ring at the
//   write index, start sets the write index to 0 and the read index to half
//   the ring, emit builds one packet from the ring. command 3 does nothing.
// store and start leave busy low; the block can take a new item right away.
// emit: the packet is sized in ST_LEN, then for each source word the ring is
//   read (ST_READ) and the output register loaded (ST_SEND), plus a copy from
//   ST_DUP in mono-to-stereo mode, where the next source word is skipped. busy
//   stays high until the last word is sent, so no item is taken meanwhile; the
//   single ring read port sets the pace.
// result channel: each packet word is on sample_word/last_word/packet_words
//   for exactly one cycle with result_valid high. the receiver cannot stall;
//   every word must be taken when shown.
// config channel: cfg_ready is always high, a write lands at the edge with
//   cfg_valid high. write only while busy is low and no packet word is pending.
// reset: sets state, index and config registers to defaults, then zeroes the
//   whole ring, one entry per cycle, busy high; config writes are still taken.
module audio_ring_packetizer
	import arp_pkg::*;
#(
	parameter int unsigned RING_DEPTH       = 128,
	parameter int unsigned MAX_PACKET_WORDS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	// item channel
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        command,
	input  logic [WORD_W-1:0] captured_word,
	// result channel
	output logic              result_valid,
	output logic [WORD_W-1:0] sample_word,
	output logic              last_word,
	output logic [LEN_W-1:0]  packet_words,
	// configuration channel
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_data
);

	arp_ctl_t  ctl;
	arp_stat_t stat;

	// registers are plain flops, a write never has to wait
	assign cfg_ready = 1'b1;

	arp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.stat    (stat),
		.busy    (busy),
		.ctl     (ctl)
	);

	arp_datapath #(
		.RING_DEPTH       (RING_DEPTH),
		.MAX_PACKET_WORDS (MAX_PACKET_WORDS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.captured_word (captured_word),
		.cfg_wr        (cfg_valid & cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.stat          (stat),
		.result_valid  (result_valid),
		.sample_word   (sample_word),
		.last_word     (last_word),
		.packet_words  (packet_words)
	);

endmodule
